@@ hw/rtl/rbi_pkg.sv @@
// ---------------------------------------------------------------------------
// rbi_pkg: shared types and constants for the rigid body integrator
// Fixed-point widths, register indexes, sequencer states and saturation.
// ---------------------------------------------------------------------------
package rbi_pkg;

    localparam int FRAC_BITS = 16;   // Q format of force, mass and moment math
    localparam int STEP_FRAC = 16;   // step_time is Q0.16

    localparam int MUL_W  = 33;      // signed operand width of the shared multiplier
    localparam int PROD_W = 2 * MUL_W;

    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_INV_MASS    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INV_MOMENT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SLEEP_SPEED = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SLEEP_DELAY = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_KINEMATIC   = 3'd4;

    localparam logic [31:0] INV_MASS_RST    = 32'd65536;
    localparam logic [31:0] INV_MOMENT_RST  = 32'd65536;
    localparam logic [15:0] SLEEP_SPEED_RST = 16'd1;
    localparam logic [7:0]  SLEEP_DELAY_RST = 8'd30;
    localparam logic [7:0]  REST_COUNT_RST  = 8'd30;

    localparam logic CMD_TICK  = 1'b0;
    localparam logic CMD_FORCE = 1'b1;

    // last sequencer step of both the tick and the force sequence
    localparam logic [2:0] STEP_LAST = 3'd6;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_TICK,
        ST_FORCE,
        ST_DONE
    } rbi_state_t;

    localparam logic signed [PROD_W-1:0] SAT_HI = PROD_W'(64'sd2147483647);
    localparam logic signed [PROD_W-1:0] SAT_LO = PROD_W'(-64'sd2147483648);

    function automatic logic signed [31:0] sat32(input logic signed [PROD_W-1:0] v);
        logic signed [31:0] r;
        if (v > SAT_HI) begin
            r = 32'sh7FFF_FFFF;
        end else if (v < SAT_LO) begin
            r = 32'sh8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

@@ hw/rtl/rbi_mul.sv @@
// ---------------------------------------------------------------------------
// rbi_mul: shared signed multiplier
// One 33x33 signed multiply per cycle, product registered.
// ---------------------------------------------------------------------------
module rbi_mul
    import rbi_pkg::*;
(
    input  logic                     aclk,
    input  logic signed [MUL_W-1:0]  op_a,
    input  logic signed [MUL_W-1:0]  op_b,
    output logic signed [PROD_W-1:0] prod
);

    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] prod_next;

    assign prod_next = op_a * op_b;

    always_ff @(posedge aclk) begin
        prod_reg <= prod_next;
    end

    assign prod = prod_reg;

endmodule

@@ hw/rtl/rigid_body_integrator_with_sleep_unit.sv @@
// ---------------------------------------------------------------------------
// rigid_body_integrator_with_sleep_unit: 2D rigid body state with sleep
// Explicit Euler step, force/torque push and rest detection in Q16.16.
// ---------------------------------------------------------------------------
// Usage:
//   Slave channel s_*: one transfer per command. s_tuser[0] is the command
//   (0 time tick, 1 apply force); s_tdata carries step time, force, arm
//   and wake. Master channel m_*: one transfer per command with the body
//   state after that command (position, angle, velocity, spin, awake).
//   cfg_*: write-only register port, one write per cycle; the user writes
//   only while idle, which the block does not enforce.
//   Force commands and unfrozen ticks walk a 7-step sequence around one
//   shared 33x33 multiplier (product registered), then a done state loads
//   the result register once it is free, raising m_tvalid; the sequencer
//   then returns to idle to take the next transfer.
//   Frozen ticks (kinematic or asleep) skip to the done state after 1 step.
//   s_tready is high only while the sequencer is idle.
// Stalls: the result register holds its transfer until m_tready; the
//   next command may run meanwhile and waits at its end for a free slot.
// Reset (aresetn low, synchronous): body at origin, at rest, awake,
//   rest counter 30, registers at their defaults, no result pending.
// ---------------------------------------------------------------------------
module rigid_body_integrator_with_sleep_unit
    import rbi_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    // config write port
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_addr,
    input  logic [CFG_DAT_W-1:0] cfg_wdata,
    // slave stream
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // [15:0] step_time, [47:16] force_x, [79:48] force_y, [111:80] arm_x,
    // [143:112] arm_y, [144] wake, [151:145] zero
    input  logic [151:0]         s_tdata,
    // [0] cmd
    input  logic [0:0]           s_tuser,
    // master stream
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // [31:0] pos_x, [63:32] pos_y, [95:64] angle, [127:96] vel_x,
    // [159:128] vel_y, [191:160] spin, [192] awake_out, [199:193] zero
    output logic [199:0]         m_tdata
);

    // ---------------- configuration registers ----------------
    logic [31:0] inv_mass_reg;
    logic [31:0] inv_moment_reg;
    logic [15:0] sleep_speed_reg;
    logic [7:0]  sleep_delay_reg;
    logic        kinematic_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            inv_mass_reg    <= INV_MASS_RST;
            inv_moment_reg  <= INV_MOMENT_RST;
            sleep_speed_reg <= SLEEP_SPEED_RST;
            sleep_delay_reg <= SLEEP_DELAY_RST;
            kinematic_reg   <= 1'b0;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                REG_INV_MASS:    inv_mass_reg    <= cfg_wdata;
                REG_INV_MOMENT:  inv_moment_reg  <= cfg_wdata;
                REG_SLEEP_SPEED: sleep_speed_reg <= cfg_wdata[15:0];
                REG_SLEEP_DELAY: sleep_delay_reg <= cfg_wdata[7:0];
                REG_KINEMATIC:   kinematic_reg   <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // ---------------- input capture ----------------
    logic [15:0]        dt_reg;
    logic signed [31:0] fx_reg;
    logic signed [31:0] fy_reg;
    logic signed [31:0] ax_reg;
    logic signed [31:0] ay_reg;
    logic               wake_reg;

    logic in_xfer;
    assign in_xfer = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (in_xfer) begin
            dt_reg   <= s_tdata[15:0];
            fx_reg   <= s_tdata[47:16];
            fy_reg   <= s_tdata[79:48];
            ax_reg   <= s_tdata[111:80];
            ay_reg   <= s_tdata[143:112];
            wake_reg <= s_tdata[144];
        end
    end

    // ---------------- body state ----------------
    logic [31:0]        pos_x_reg;
    logic [31:0]        pos_y_reg;
    logic [31:0]        angle_reg;
    logic signed [31:0] vel_x_reg;
    logic signed [31:0] vel_y_reg;
    logic signed [31:0] spin_reg;
    logic               awake_reg;
    logic [7:0]         rest_cnt_reg;

    // scratch
    logic [63:0]              speed2_reg;   // |v|^2 accumulator
    logic signed [PROD_W-1:0] torque_reg;   // fy*ax held for the subtract
    logic signed [31:0]       tq_reg;       // saturated torque >> FRAC_BITS

    // ---------------- sequencer ----------------
    rbi_state_t state_reg, state_next;
    logic [2:0] step_reg, step_next;

    logic out_free;
    logic frozen;
    logic load_out;

    logic               m_tvalid_reg;
    logic [199:0]       m_tdata_reg;

    assign out_free = !m_tvalid_reg || m_tready;
    assign frozen   = kinematic_reg || !awake_reg;

    // next state
    always_comb begin
        state_next = state_reg;
        step_next  = step_reg;
        case (state_reg)
            ST_IDLE: begin
                step_next = 3'd0;
                if (s_tvalid) begin
                    state_next = (s_tuser[0] == CMD_FORCE) ? ST_FORCE : ST_TICK;
                end
            end
            ST_TICK: begin
                step_next = step_reg + 3'd1;
                if (frozen || step_reg == STEP_LAST) begin
                    state_next = ST_DONE;
                end
            end
            ST_FORCE: begin
                step_next = step_reg + 3'd1;
                if (step_reg == STEP_LAST) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        s_tready = 1'b0;
        load_out = 1'b0;
        case (state_reg)
            ST_IDLE: s_tready = 1'b1;
            ST_DONE: load_out = out_free;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            step_reg  <= 3'd0;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    // ---------------- shared multiplier ----------------
    logic signed [MUL_W-1:0]  mul_a;
    logic signed [MUL_W-1:0]  mul_b;
    logic signed [PROD_W-1:0] prod;

    rbi_mul u_mul (
        .aclk (aclk),
        .op_a (mul_a),
        .op_b (mul_b),
        .prod (prod)
    );

    logic signed [MUL_W-1:0] vx_abs;
    logic signed [MUL_W-1:0] vy_abs;
    logic signed [MUL_W-1:0] w_abs;
    logic signed [MUL_W-1:0] dt_op;
    logic signed [MUL_W-1:0] ss_op;

    assign vx_abs = vel_x_reg[31] ? -{vel_x_reg[31], vel_x_reg} : {1'b0, vel_x_reg};
    assign vy_abs = vel_y_reg[31] ? -{vel_y_reg[31], vel_y_reg} : {1'b0, vel_y_reg};
    assign w_abs  = spin_reg[31]  ? -{spin_reg[31], spin_reg}   : {1'b0, spin_reg};
    assign dt_op  = {17'd0, dt_reg};
    assign ss_op  = {17'd0, sleep_speed_reg};

    // operand select: step k issues a multiply whose product is used at step k+1
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        if (state_reg == ST_TICK) begin
            case (step_reg)
                3'd0: begin mul_a = {vel_x_reg[31], vel_x_reg}; mul_b = dt_op; end
                3'd1: begin mul_a = {vel_y_reg[31], vel_y_reg}; mul_b = dt_op; end
                3'd2: begin mul_a = {spin_reg[31], spin_reg};   mul_b = dt_op; end
                3'd3: begin mul_a = vx_abs; mul_b = vx_abs; end
                3'd4: begin mul_a = vy_abs; mul_b = vy_abs; end
                3'd5: begin mul_a = ss_op;  mul_b = ss_op;  end
                default: ;
            endcase
        end else if (state_reg == ST_FORCE) begin
            case (step_reg)
                3'd0: begin mul_a = {fx_reg[31], fx_reg}; mul_b = {1'b0, inv_mass_reg}; end
                3'd1: begin mul_a = {fy_reg[31], fy_reg}; mul_b = {1'b0, inv_mass_reg}; end
                3'd2: begin mul_a = {fy_reg[31], fy_reg}; mul_b = {ax_reg[31], ax_reg}; end
                3'd3: begin mul_a = {fx_reg[31], fx_reg}; mul_b = {ay_reg[31], ay_reg}; end
                3'd5: begin mul_a = {tq_reg[31], tq_reg}; mul_b = {1'b0, inv_moment_reg}; end
                default: ;
            endcase
        end
    end

    // ---------------- result arithmetic ----------------
    logic [31:0]              step_delta;   // floor(prod >> STEP_FRAC) mod 2^32
    logic signed [PROD_W-1:0] push;         // floor(prod >> FRAC_BITS)
    logic signed [PROD_W-1:0] torque_diff;
    logic signed [31:0]       vx_sum;
    logic signed [31:0]       vy_sum;
    logic signed [31:0]       spin_sum;
    logic                     resting;
    logic                     arm_nonzero;

    assign step_delta  = prod[STEP_FRAC +: 32];
    assign push        = prod >>> FRAC_BITS;
    assign torque_diff = torque_reg - prod;
    assign vx_sum      = sat32(PROD_W'(vel_x_reg) + push);
    assign vy_sum      = sat32(PROD_W'(vel_y_reg) + push);
    assign spin_sum    = sat32(PROD_W'(spin_reg) + push);
    assign resting     = (speed2_reg < prod[63:0]) && (w_abs < ss_op);
    assign arm_nonzero = (ax_reg != 32'sd0) || (ay_reg != 32'sd0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_x_reg    <= '0;
            pos_y_reg    <= '0;
            angle_reg    <= '0;
            vel_x_reg    <= '0;
            vel_y_reg    <= '0;
            spin_reg     <= '0;
            awake_reg    <= 1'b1;
            rest_cnt_reg <= REST_COUNT_RST;
        end else if (state_reg == ST_TICK) begin
            if (frozen) begin
                vel_x_reg <= '0;
                vel_y_reg <= '0;
                spin_reg  <= '0;
            end else begin
                case (step_reg)
                    3'd1: pos_x_reg  <= pos_x_reg + step_delta;
                    3'd2: pos_y_reg  <= pos_y_reg + step_delta;
                    3'd3: angle_reg  <= angle_reg + step_delta;
                    3'd4: speed2_reg <= prod[63:0];
                    3'd5: speed2_reg <= speed2_reg + prod[63:0];
                    3'd6: begin
                        if (resting) begin
                            if (rest_cnt_reg == 8'd0) begin
                                awake_reg <= 1'b0;
                                vel_x_reg <= '0;
                                vel_y_reg <= '0;
                                spin_reg  <= '0;
                            end else begin
                                rest_cnt_reg <= rest_cnt_reg - 8'd1;
                            end
                        end else begin
                            rest_cnt_reg <= sleep_delay_reg;
                        end
                    end
                    default: ;
                endcase
            end
        end else if (state_reg == ST_FORCE) begin
            case (step_reg)
                3'd1: vel_x_reg  <= vx_sum;
                3'd2: vel_y_reg  <= vy_sum;
                3'd3: torque_reg <= prod;
                3'd4: tq_reg     <= sat32(torque_diff >>> FRAC_BITS);
                3'd6: begin
                    if (arm_nonzero) begin
                        spin_reg <= spin_sum;
                    end
                    if (wake_reg) begin
                        awake_reg    <= 1'b1;
                        rest_cnt_reg <= sleep_delay_reg;
                    end
                end
                default: ;
            endcase
        end
    end

    // ---------------- result register ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (load_out) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_out) begin
            m_tdata_reg <= {7'd0, awake_reg, spin_reg, vel_y_reg, vel_x_reg,
                            angle_reg, pos_y_reg, pos_x_reg};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

@@ dv/rigid_body_integrator_with_sleep_unit_tb.sv @@
// ---------------------------------------------------------------------------
// rigid_body_integrator_with_sleep_unit_tb: self-checking bench for the body unit
// Drives tick and force commands on the slave stream and tracks the body state
// in a Q16.16 predictor of its own. Every result transfer is checked field by
// field against the state that was predicted for the oldest open command.
// Register settings change between phases. Both stream sides stall at random.
// ---------------------------------------------------------------------------
module rigid_body_integrator_with_sleep_unit_tb
    import rbi_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SETTLE_CYCLES = 16;      // drain margin after every open result is back
    localparam int PHASE_ITEMS   = 170;
    localparam int PHASES        = 6;
    localparam int BACKLOG_HOLD  = 300;     // long receiver hold-off, in cycles
    localparam int MAX_REPORTS   = 30;

    // index past the register list, must be ignored by the unit
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

    localparam logic [31:0] S32_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] S32_MIN = 32'h8000_0000;

    // -----------------------------------------------------------------------
    // Body state predictor and result scoreboard
    // -----------------------------------------------------------------------
    class body_state_scoreboard;
        // register copies
        logic [31:0] inv_mass;
        logic [31:0] inv_moment;
        logic [15:0] sleep_speed;
        logic [7:0]  sleep_delay;
        logic        kinematic;
        // body state
        logic signed [31:0] pos_x, pos_y, angle;
        logic signed [31:0] vel_x, vel_y, spin;
        logic               awake;
        logic [7:0]         rest_count;

        logic [199:0] pending_states[$];
        int errors;
        int checked;
        int ticks, pushes, naps, wakeups, clamps;

        function new();
            inv_mass    = INV_MASS_RST;
            inv_moment  = INV_MOMENT_RST;
            sleep_speed = SLEEP_SPEED_RST;
            sleep_delay = SLEEP_DELAY_RST;
            kinematic   = 1'b0;
            pos_x = '0; pos_y = '0; angle = '0;
            vel_x = '0; vel_y = '0; spin  = '0;
            awake      = 1'b1;
            rest_count = REST_COUNT_RST;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] val);
            case (idx)
                REG_INV_MASS:    inv_mass    = val;
                REG_INV_MOMENT:  inv_moment  = val;
                REG_SLEEP_SPEED: sleep_speed = val[15:0];
                REG_SLEEP_DELAY: sleep_delay = val[7:0];
                REG_KINEMATIC:   kinematic   = val[0];
                default: ;
            endcase
        endfunction

        function int pending();
            return pending_states.size();
        endfunction

        // clamp to signed 32 bits, counting every clipped update
        function logic signed [31:0] clamp_s32(logic signed [95:0] v);
            if (v > 96'sd2147483647) begin
                clamps++;
                return S32_MAX;
            end
            if (v < -96'sd2147483648) begin
                clamps++;
                return S32_MIN;
            end
            return v[31:0];
        endfunction

        function void stop_motion();
            vel_x = '0;
            vel_y = '0;
            spin  = '0;
        endfunction

        // advance the body by one accepted command, queue the state it leaves
        function void note_command(logic cmd, logic [151:0] d);
            logic signed [95:0] fxw, fyw, axw, ayw, vxw, vyw, ww, dtw;
            logic signed [95:0] acc, tq, gain, ssw, speed2, spin_abs;
            fxw = $signed(d[47:16]);
            fyw = $signed(d[79:48]);
            axw = $signed(d[111:80]);
            ayw = $signed(d[143:112]);
            dtw = {80'd0, d[15:0]};
            vxw = vel_x;
            vyw = vel_y;
            ww  = spin;
            if (cmd == CMD_FORCE) begin
                pushes++;
                gain  = {64'd0, inv_mass};
                acc   = vxw + ((fxw * gain) >>> FRAC_BITS);
                vel_x = clamp_s32(acc);
                acc   = vyw + ((fyw * gain) >>> FRAC_BITS);
                vel_y = clamp_s32(acc);
                if (axw != 0 || ayw != 0) begin
                    acc  = fyw * axw - fxw * ayw;
                    tq   = clamp_s32(acc >>> FRAC_BITS);
                    gain = {64'd0, inv_moment};
                    acc  = ww + ((tq * gain) >>> FRAC_BITS);
                    spin = clamp_s32(acc);
                end
                if (d[144]) begin
                    if (!awake) wakeups++;
                    awake      = 1'b1;
                    rest_count = sleep_delay;
                end
            end else begin
                ticks++;
                if (kinematic || !awake) begin
                    stop_motion();
                end else begin
                    acc   = (vxw * dtw) >>> STEP_FRAC;
                    pos_x = pos_x + acc[31:0];
                    acc   = (vyw * dtw) >>> STEP_FRAC;
                    pos_y = pos_y + acc[31:0];
                    acc   = (ww * dtw) >>> STEP_FRAC;
                    angle = angle + acc[31:0];
                    // rest test uses the velocities from before the step
                    ssw      = {80'd0, sleep_speed};
                    speed2   = vxw * vxw + vyw * vyw;
                    spin_abs = (ww < 0) ? -ww : ww;
                    if (speed2 < ssw * ssw && spin_abs < ssw) begin
                        if (rest_count == 8'd0) begin
                            naps++;
                            awake = 1'b0;
                            stop_motion();
                        end else begin
                            rest_count = rest_count - 8'd1;
                        end
                    end else begin
                        rest_count = sleep_delay;
                    end
                end
            end
            pending_states.push_back({7'd0, awake, spin, vel_y, vel_x, angle, pos_y, pos_x});
        endfunction

        function void check_state(logic [199:0] got);
            string names[7];
            logic [199:0] want;
            names = '{"pos_x", "pos_y", "angle", "vel_x", "vel_y", "spin", "awake_out"};
            if (pending_states.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: result transfer with nothing expected, got %h", $time, got);
                return;
            end
            want = pending_states.pop_front();
            checked++;
            for (int i = 0; i < 6; i++) begin
                if (got[32*i +: 32] !== want[32*i +: 32]) begin
                    errors++;
                    if (errors <= MAX_REPORTS)
                        $display("%0t: %s mismatch, expected %h, actual %h", $time, names[i],
                                 want[32*i +: 32], got[32*i +: 32]);
                end
            end
            if (got[192] !== want[192]) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: %s mismatch, expected %b, actual %b", $time, names[6],
                             want[192], got[192]);
            end
        endfunction
    endclass

    // -----------------------------------------------------------------------
    // DUT hookup
    // -----------------------------------------------------------------------
    logic                 aclk;
    logic                 aresetn;
    logic                 cfg_wr_en;
    logic [CFG_IDX_W-1:0] cfg_addr;
    logic [CFG_DAT_W-1:0] cfg_wdata;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [151:0]         s_tdata;    // step_time, force_x, force_y, arm_x, arm_y, wake
    logic [0:0]           s_tuser;    // cmd
    logic                 m_tvalid;
    logic                 m_tready;
    logic [199:0]         m_tdata;    // pos_x, pos_y, angle, vel_x, vel_y, spin, awake_out

    rigid_body_integrator_with_sleep_unit u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    body_state_scoreboard sb = new();

    int items_taken;        // slave transfers seen, bumped at the rising edge
    int src_idle_pct;
    int snk_idle_pct;
    bit hold_off_req;       // asks the sink for one long hold-off
    int settings_used;

    // 8 ns clock
    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // Hard stop, far beyond the slowest legal run (~1040 commands, even with
    // both sides stalling).
    initial begin
        #5ms;
        $display("timeout: %0d results still open", sb.pending());
        $display("== FAIL ==");
        $finish;
    end

    // -----------------------------------------------------------------------
    // Monitor: everything sampled on the rising edge; stimulus moves on the
    // falling edge, so the sampled values are settled.
    // -----------------------------------------------------------------------
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) sb.check_state(m_tdata);
            if (s_tvalid && s_tready) begin
                sb.note_command(s_tuser[0], s_tdata);
                items_taken++;
            end
        end
    end

    // -----------------------------------------------------------------------
    // Result sink: random back-pressure, plus one long hold-off on request
    // so the result slot and the sequencer both fill and s_tready drops.
    // -----------------------------------------------------------------------
    initial begin : result_sink
        int hold;
        hold = 0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                hold = BACKLOG_HOLD;
            end
            if (hold > 0) begin
                hold--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= snk_idle_pct);
            end
        end
    end

    // -----------------------------------------------------------------------
    // Driver tasks; all entered and left on a falling edge
    // -----------------------------------------------------------------------
    // Register writes, one per cycle, then a write to an unused index.
    task automatic load_settings(input logic [31:0] im, input logic [31:0] mo,
                                 input logic [15:0] ss, input logic [7:0] dl,
                                 input logic kin);
        logic [CFG_IDX_W-1:0] idx[5];
        logic [CFG_DAT_W-1:0] val[5];
        idx = '{REG_INV_MASS, REG_INV_MOMENT, REG_SLEEP_SPEED, REG_SLEEP_DELAY,
                REG_KINEMATIC};
        val = '{im, mo, {16'd0, ss}, {24'd0, dl}, {31'd0, kin}};
        for (int i = 0; i < 5; i++) begin
            cfg_addr  <= idx[i];
            cfg_wdata <= val[i];
            cfg_wr_en <= 1'b1;
            sb.write_reg(idx[i], val[i]);
            @(negedge aclk);
        end
        cfg_addr  <= REG_UNUSED;
        cfg_wdata <= $urandom;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        settings_used++;
    endtask

    // One command transfer. tvalid stays high into the next command unless
    // a random gap is drawn, so it is never dropped and raised in one step.
    task automatic push_item(input logic cmd, input logic [151:0] payload);
        int gap;
        int target;
        gap = 0;
        while (gap < 12 && $urandom_range(99) < src_idle_pct) gap++;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        target = items_taken + 1;
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= payload;
        do @(negedge aclk); while (items_taken < target);
    endtask

    // Stop offering and wait for every open result, then a margin.
    task automatic settle();
        s_tvalid <= 1'b0;
        do @(negedge aclk); while (sb.pending() != 0);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    function automatic logic [151:0] pack_item(logic [15:0] dt, logic [31:0] fx,
                                               logic [31:0] fy, logic [31:0] ax,
                                               logic [31:0] ay, logic wk);
        return {7'd0, wk, ay, ax, fy, fx, dt};
    endfunction

    // Mostly small forces so bodies can come to rest, with full-range,
    // extreme and mid-size values mixed in.
    function automatic logic [31:0] pick_operand();
        int r;
        logic [31:0] v;
        r = $urandom_range(99);
        if (r < 60) begin
            v = $urandom_range(8191) - 4096;
        end else if (r < 75) begin
            v = $urandom;
        end else if (r < 85) begin
            case ($urandom_range(3))
                0:       v = S32_MAX;
                1:       v = S32_MIN;
                2:       v = 32'd0;
                default: v = 32'hFFFF_FFFF;
            endcase
        end else begin
            v = $urandom_range(32'h1F_FFFF) - 32'h10_0000;
        end
        return v;
    endfunction

    task automatic push_random_item();
        logic [15:0] dt;
        logic [31:0] ax, ay;
        int r;
        r = $urandom_range(9);
        dt = (r == 0) ? 16'd0 : (r == 1) ? 16'hFFFF : 16'($urandom);
        if ($urandom_range(99) < 55) begin
            // tick: unused fields carry junk
            push_item(CMD_TICK, pack_item(dt, $urandom, $urandom, $urandom, $urandom,
                                          1'($urandom)));
        end else begin
            ax = 32'd0;
            ay = 32'd0;
            if ($urandom_range(99) >= 30) begin
                ax = pick_operand();
                ay = pick_operand();
            end
            push_item(CMD_FORCE, pack_item(16'($urandom), pick_operand(), pick_operand(),
                                           ax, ay, ($urandom_range(99) < 20)));
        end
    endtask

    // -----------------------------------------------------------------------
    // Main sequence
    // -----------------------------------------------------------------------
    initial begin : stimulus
        aresetn      = 1'b0;
        cfg_wr_en    = 1'b0;
        cfg_addr     = '0;
        cfg_wdata    = '0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tuser      = CMD_TICK;
        m_tready     = 1'b0;
        items_taken  = 0;
        hold_off_req = 1'b0;
        src_idle_pct = 21;
        snk_idle_pct = 54;
        settings_used = 0;

        repeat (7) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // ---- directed: extremes, saturation, torque, ignored fields ----
        load_settings(32'h0001_0000, 32'h0001_0000, 16'd1, 8'd2, 1'b0);
        push_item(CMD_TICK,  pack_item(16'hFFFF, $urandom, $urandom, $urandom, $urandom, 1'b1));
        push_item(CMD_FORCE, pack_item(16'hFFFF, S32_MAX, S32_MIN, 32'd0, 32'd0, 1'b0));
        push_item(CMD_FORCE, pack_item(16'h0000, S32_MAX, S32_MIN, 32'd0, 32'd0, 1'b0));
        push_item(CMD_TICK,  pack_item(16'hFFFF, 32'd0, 32'd0, 32'd0, 32'd0, 1'b0));
        // torque clips high, then low twice to drive spin into the rail
        push_item(CMD_FORCE, pack_item(16'h1234, S32_MAX, S32_MAX, S32_MAX, S32_MIN, 1'b1));
        push_item(CMD_FORCE, pack_item(16'h0000, S32_MIN, S32_MIN, S32_MAX, S32_MIN, 1'b0));
        push_item(CMD_FORCE, pack_item(16'h0000, S32_MIN, S32_MIN, S32_MAX, S32_MIN, 1'b0));
        push_item(CMD_TICK,  pack_item(16'hFFFF, $urandom, $urandom, $urandom, $urandom, 1'b1));
        push_item(CMD_FORCE, pack_item(16'h0000, 32'h0000_0100, 32'hFFFF_FF00,
                                       32'h0001_0000, 32'hFFFF_0000, 1'b1));
        settle();

        // kinematic body: tick clears motion, force still moves velocity
        load_settings(32'h0001_0000, 32'h0001_0000, 16'd1, 8'd1, 1'b1);
        push_item(CMD_TICK,  pack_item(16'h8000, 32'd0, 32'd0, 32'd0, 32'd0, 1'b0));
        push_item(CMD_FORCE, pack_item(16'h0000, 32'h0000_0800, 32'h0000_0400,
                                       32'd0, 32'd0, 1'b0));
        push_item(CMD_TICK,  pack_item(16'h8000, 32'd0, 32'd0, 32'd0, 32'd0, 1'b0));
        settle();

        // rest countdown to sleep, asleep push, wake with zero arm
        load_settings(32'h0001_0000, 32'h0001_0000, 16'd1, 8'd1, 1'b0);
        push_item(CMD_FORCE, pack_item(16'hFFFF, 32'd0, 32'd0, 32'd0, 32'd0, 1'b1));
        push_item(CMD_TICK,  pack_item(16'h4000, $urandom, $urandom, $urandom, $urandom, 1'b0));
        push_item(CMD_TICK,  pack_item(16'h4000, 32'd0, 32'd0, 32'd0, 32'd0, 1'b0));
        push_item(CMD_TICK,  pack_item(16'hFFFF, 32'd0, 32'd0, 32'd0, 32'd0, 1'b1));
        push_item(CMD_FORCE, pack_item(16'h0000, 32'h0002_0000, 32'hFFFE_0000,
                                       32'h0000_8000, 32'd0, 1'b0));
        push_item(CMD_TICK,  pack_item(16'hFFFF, 32'd0, 32'd0, 32'd0, 32'd0, 1'b0));
        push_item(CMD_FORCE, pack_item(16'hABCD, 32'h0003_0000, 32'd0, 32'd0, 32'd0, 1'b1));
        push_item(CMD_TICK,  pack_item(16'h1000, $urandom, $urandom, $urandom, $urandom, 1'b0));
        push_item(CMD_FORCE, pack_item(16'hFFFF, 32'hFFFF_FFFF, 32'h0000_0001,
                                       32'h0000_0001, 32'hFFFF_FFFF, 1'b0));
        settle();

        // ---- random phases, one register setting each ----
        for (int p = 0; p < PHASES; p++) begin
            // sender 21 / sink 54, then swapped, then no idling at all
            src_idle_pct = (p < 2) ? 21 : (p < 4) ? 54 : 0;
            snk_idle_pct = (p < 2) ? 54 : (p < 4) ? 21 : 0;
            case (p)
                0: load_settings(32'h0001_0000, 32'h0001_0000, 16'hFFFF, 8'd0, 1'b0);
                1: load_settings(32'hFFFF_FFFF, 32'd0, 16'd0, 8'd255, 1'b0);
                2: load_settings(32'd0, 32'hFFFF_FFFF, 16'($urandom_range(65535, 1024)),
                                 8'($urandom_range(15)), 1'b0);
                3: load_settings($urandom, $urandom, 16'($urandom), 8'($urandom), 1'b1);
                4: load_settings($urandom_range(32'h2_0000), $urandom_range(32'h4_0000),
                                 16'($urandom_range(65535, 4096)), 8'($urandom_range(8)), 1'b0);
                default: load_settings($urandom, $urandom, 16'($urandom_range(65535)),
                                       8'($urandom_range(255)), 1'b0);
            endcase
            // long sink stall while commands keep coming: unit backs up
            if (p == 1) hold_off_req = 1'b1;
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                // sender pause until every open result is back
                if (p == 2 && i == PHASE_ITEMS / 2) settle();
                push_random_item();
            end
            settle();
        end

        $display("run covered %0d ticks and %0d force transfers over %0d register settings",
                 sb.ticks, sb.pushes, settings_used);
        $display("body fell asleep %0d times, was woken %0d times, %0d clipped updates",
                 sb.naps, sb.wakeups, sb.clamps);
        $display("%0d results checked", sb.checked);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("%0d mismatches, %0d results never arrived", sb.errors, sb.pending());
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
